[sv/wpbe_pkg.sv]
// Package: shared types and constants of the WS2812 bit encoder.
`default_nettype none

package wpbe_pkg;

  typedef enum logic [1:0] {
    REQ_DATA  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam logic [1:0] CFG_ZERO_HIGH  = 2'd0;
  localparam logic [1:0] CFG_ONE_HIGH   = 2'd1;
  localparam logic [1:0] CFG_BIT_PERIOD = 2'd2;

  localparam logic [7:0] ZERO_HIGH_RST  = 8'd17;
  localparam logic [7:0] ONE_HIGH_RST   = 8'd35;
  localparam logic [7:0] BIT_PERIOD_RST = 8'd62;

  localparam logic [7:0] FILL_BYTE = 8'h00;

  localparam int RES_Q_DEPTH = 4;
  localparam int RES_Q_AW    = 2;
  localparam int RES_Q_CW    = 3;

  typedef struct packed {
    logic [7:0] zero_high;
    logic [7:0] one_high;
    logic [7:0] bit_period;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       active;
    logic       pop;
    logic [2:0] bit_idx;
    logic [7:0] cell_ticks;
    logic       busy;
    logic       ovf;
  } cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic overflow;
  } res_t;

endpackage

`default_nettype wire

[sv/wpbe_if.sv]
// Interfaces: request and result channels of the WS2812 bit encoder.
`default_nettype none

interface wpbe_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

interface wpbe_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic overflow;

  modport source (output valid, output line_level, output busy_res, output overflow,
                  input ready);
  modport sink (input valid, input line_level, input busy_res, input overflow,
                output ready);
endinterface

`default_nettype wire

[sv/wpbe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wpbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/wpbe_front.sv]
// Front: triplet reorder, byte queue pointers and bit cell timing.
`default_nettype none

module wpbe_front #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [1:0]                     req_type,
  input  wire logic [7:0]                     data_byte,
  input  wire wpbe_pkg::cfg_t                 cfg,
  output logic                                cmd_valid,
  output wpbe_pkg::cmd_t                      cmd,
  output logic                                ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                          ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_raddr
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL    = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL_M1 = CW'(QUEUE_DEPTH - 1);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [CW-1:0]     count, count_next;
  logic [7:0]        held, held_next;
  wpbe_pkg::phase_t  phase, phase_next;
  logic              sending, sending_next;
  logic [2:0]        bit_idx, bit_idx_next;
  logic [7:0]        cell_ticks, cell_ticks_next;
  logic              pend_valid, pend_valid_next;
  logic [AW-1:0]     pend_addr, pend_addr_next;
  logic [7:0]        pend_data, pend_data_next;

  wpbe_pkg::req_t    req;
  logic [1:0]        n_req;
  logic [7:0]        p0, p1;
  logic              ok0, ok1, ovf, pop, act;
  logic [2:0]        bi;
  logic [7:0]        ct;

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      held       <= '0;
      phase      <= wpbe_pkg::PH_FIRST;
      sending    <= 1'b0;
      bit_idx    <= '0;
      cell_ticks <= '0;
      pend_valid <= 1'b0;
    end else begin
      head       <= head_next;
      tail       <= tail_next;
      count      <= count_next;
      held       <= held_next;
      phase      <= phase_next;
      sending    <= sending_next;
      bit_idx    <= bit_idx_next;
      cell_ticks <= cell_ticks_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    pend_data <= pend_data_next;
  end

  always_comb begin
    req             = wpbe_pkg::req_t'(req_type);
    held_next       = held;
    phase_next      = phase;
    sending_next    = sending;
    bit_idx_next    = bit_idx;
    cell_ticks_next = cell_ticks;
    head_next       = head;
    n_req           = 2'd0;
    p0              = data_byte;
    p1              = held;
    pop             = 1'b0;
    act             = 1'b0;
    bi              = bit_idx;
    ct              = cell_ticks;

    if (accept) begin
      case (req)
        wpbe_pkg::REQ_DATA: begin
          case (phase)
            wpbe_pkg::PH_FIRST: begin
              held_next  = data_byte;
              phase_next = wpbe_pkg::PH_SECOND;
            end
            wpbe_pkg::PH_SECOND: begin
              n_req      = 2'd2;
              phase_next = wpbe_pkg::PH_THIRD;
            end
            wpbe_pkg::PH_THIRD: begin
              n_req      = 2'd1;
              phase_next = wpbe_pkg::PH_FIRST;
            end
            default: begin
              phase_next = wpbe_pkg::PH_FIRST;
            end
          endcase
        end
        wpbe_pkg::REQ_TICK: begin
          pop = !sending && (count != '0);
          act = sending || pop;
          if (pop) begin
            head_next = wrap_inc(head);
            bi        = '0;
            ct        = '0;
          end
          if (act) begin
            sending_next = 1'b1;
            if (({1'b0, ct} + 9'd1) >= {1'b0, cfg.bit_period}) begin
              cell_ticks_next = '0;
              if (bi == 3'd7) begin
                bit_idx_next = '0;
                sending_next = 1'b0;
              end else begin
                bit_idx_next = bi + 3'd1;
              end
            end else begin
              cell_ticks_next = ct + 8'd1;
              bit_idx_next    = bi;
            end
          end
        end
        wpbe_pkg::REQ_FLUSH: begin
          if (phase == wpbe_pkg::PH_SECOND) begin
            n_req = 2'd1;
            p0    = wpbe_pkg::FILL_BYTE;
          end
          phase_next = wpbe_pkg::PH_FIRST;
        end
        default: begin
        end
      endcase
    end

    ok0 = (n_req != 2'd0) && (count != FULL);
    ok1 = (n_req == 2'd2) && ok0 && (count != FULL_M1);
    ovf = ((n_req != 2'd0) && !ok0) || ((n_req == 2'd2) && !ok1);

    count_next = count + CW'(ok0) + CW'(ok1) - CW'(pop);
    tail_next  = ok1 ? wrap_inc(wrap_inc(tail)) : (ok0 ? wrap_inc(tail) : tail);

    // drain the pending write first, then park whatever push is left over
    if (pend_valid) begin
      ram_we          = 1'b1;
      ram_waddr       = pend_addr;
      ram_wdata       = pend_data;
      pend_valid_next = ok0;
      pend_addr_next  = tail;
      pend_data_next  = p0;
    end else begin
      ram_we          = ok0;
      ram_waddr       = tail;
      ram_wdata       = p0;
      pend_valid_next = ok1;
      pend_addr_next  = wrap_inc(tail);
      pend_data_next  = p1;
    end

    ram_re    = pop;
    ram_raddr = head;

    cmd_valid      = accept;
    cmd.tick       = accept && (req == wpbe_pkg::REQ_TICK);
    cmd.active     = act;
    cmd.pop        = pop;
    cmd.bit_idx    = bi;
    cmd.cell_ticks = ct;
    cmd.busy       = sending_next || (count_next != '0);
    cmd.ovf        = ovf;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("byte queue count above depth");

  a_pend_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && ok1))
    else $error("pending write slot overrun");

  a_pop_starts_byte: assert property (@(posedge clk) disable iff (rst)
    pop |=> sending)
    else $error("byte taken but serializer not sending");
`endif

endmodule

`default_nettype wire

[sv/wpbe_back.sv]
// Back: line level from the shift byte, and the result queue.
`default_nettype none

module wpbe_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  input  wire wpbe_pkg::cmd_t cmd,
  input  wire logic [7:0]     rdata,
  input  wire wpbe_pkg::cfg_t cfg,
  output logic                space,
  output logic                res_valid,
  input  wire logic           res_ready,
  output wpbe_pkg::res_t      res
);

  logic                             st_valid;
  wpbe_pkg::cmd_t                   st_cmd;
  logic [7:0]                       shift_byte;
  logic                             line;
  wpbe_pkg::res_t                   q [wpbe_pkg::RES_Q_DEPTH];
  logic [wpbe_pkg::RES_Q_AW-1:0]    rd_ptr, wr_ptr;
  logic [wpbe_pkg::RES_Q_CW-1:0]    q_count;

  logic [7:0]     cur;
  logic [7:0]     high;
  logic           lvl;
  logic           push, pop;
  wpbe_pkg::res_t item;

  always_comb begin
    cur             = st_cmd.pop ? rdata : shift_byte;
    high            = cur[3'd7 - st_cmd.bit_idx] ? cfg.one_high : cfg.zero_high;
    lvl             = st_cmd.tick ? (st_cmd.active && (st_cmd.cell_ticks < high)) : line;
    item.line_level = lvl;
    item.busy_res   = st_cmd.busy;
    item.overflow   = st_cmd.ovf;
    push            = st_valid;
    res_valid       = q_count != '0;
    pop             = res_valid && res_ready;
    res             = q[rd_ptr];
    space           = (q_count + wpbe_pkg::RES_Q_CW'(st_valid))
                      < wpbe_pkg::RES_Q_CW'(wpbe_pkg::RES_Q_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      line     <= 1'b0;
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      q_count  <= '0;
    end else begin
      st_valid <= cmd_valid;
      if (st_valid && st_cmd.tick) begin
        line <= lvl;
      end
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + wpbe_pkg::RES_Q_CW'(push) - wpbe_pkg::RES_Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    st_cmd <= cmd;
    if (st_valid && st_cmd.pop) begin
      shift_byte <= rdata;
    end
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

`ifndef SYNTHESIS
  a_resq_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != wpbe_pkg::RES_Q_CW'(wpbe_pkg::RES_Q_DEPTH)) || pop)
    else $error("result queue overrun");

  a_shift_load: assert property (@(posedge clk) disable iff (rst)
    (st_valid && st_cmd.pop) |=> shift_byte == $past(rdata))
    else $error("shift byte not loaded from queue");
`endif

endmodule

`default_nettype wire

[sv/ws2812_pixel_bit_encoder_unit.sv]
// Top level: WS2812 pixel bit encoder, byte queue RAM, front and back.
//
//   channel   dir   handshake            payload
//   req       in    req.valid/req.ready  req_type[1:0], data_byte[7:0]
//   res       out   res.valid/res.ready  line_level, busy_res, overflow
//   cfg       in    cfg_wr_en            cfg_index[1:0], cfg_data[7:0]
//
// One item per cycle while req.ready is high; results go via a stage register.
// The byte queue is a single-port-write RAM with registered read; a second
// byte of a reordered pair is written in the next cycle from a holding slot.
// req.ready drops only when the four-entry result queue backs up.
// Reset clears control state; byte queue RAM and data registers are not reset.
`default_nettype none

module ws2812_pixel_bit_encoder_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  wpbe_req_if.sink        req,
  wpbe_res_if.source      res,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  wpbe_pkg::cfg_t cfg;
  logic           accept;
  logic           space;
  logic           cmd_valid;
  wpbe_pkg::cmd_t cmd;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  wpbe_pkg::res_t res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_high  <= wpbe_pkg::ZERO_HIGH_RST;
      cfg.one_high   <= wpbe_pkg::ONE_HIGH_RST;
      cfg.bit_period <= wpbe_pkg::BIT_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wpbe_pkg::CFG_ZERO_HIGH:  cfg.zero_high  <= cfg_data;
        wpbe_pkg::CFG_ONE_HIGH:   cfg.one_high   <= cfg_data;
        wpbe_pkg::CFG_BIT_PERIOD: cfg.bit_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req.ready = space;
  assign accept    = req.valid && space;

  wpbe_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req.req_type),
    .data_byte (req.data_byte),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  wpbe_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_byte_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wpbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .rdata     (ram_rdata),
    .cfg       (cfg),
    .space     (space),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res       (res_item)
  );

  assign res.line_level = res_item.line_level;
  assign res.busy_res   = res_item.busy_res;
  assign res.overflow   = res_item.overflow;

endmodule

`default_nettype wire

[tb/sv/ws2812_pixel_bit_encoder_unit_test.sv]
// Testbench: WS2812 bit encoder checked item by item against a line-timing predictor.
`default_nettype none

module ws2812_pixel_bit_encoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         QUEUE_DEPTH = 16;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int         HOLD_CYCLES = 80;
  localparam int         LIMIT_NS    = 30_000_000;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  wpbe_req_if req_ch ();
  wpbe_res_if res_ch ();

  ws2812_pixel_bit_encoder_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .res      (res_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predicted encoder state
  logic [7:0]       zero_hi;
  logic [7:0]       one_hi;
  logic [7:0]       period;
  logic [7:0]       byte_ram [QUEUE_DEPTH];
  int               q_head;
  int               q_tail;
  int               q_count;
  logic [7:0]       held;
  wpbe_pkg::phase_t trip_phase;
  logic [7:0]       shifter;
  int               bit_pos;
  logic [7:0]       cell_cnt;
  bit               tx_on;
  logic             line_q;

  wpbe_pkg::res_t due_states [$];

  int  bad_count;
  int  checked_count;
  int  items_sent;
  int  dropped_items;
  int  settings_used;
  bit  steady;
  bit  hold_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit queue_byte(logic [7:0] b);
    if (q_count >= QUEUE_DEPTH) return 1'b0;
    byte_ram[q_tail] = b;
    q_tail = (q_tail + 1) % QUEUE_DEPTH;
    q_count++;
    return 1'b1;
  endfunction

  function automatic wpbe_pkg::res_t encode_item(logic [1:0] rt, logic [7:0] db);
    wpbe_pkg::res_t r;
    logic [7:0]     hi;
    bit             ovf;
    ovf = 1'b0;
    case (rt)
      wpbe_pkg::REQ_DATA: begin
        case (trip_phase)
          wpbe_pkg::PH_FIRST: begin
            held = db;
            trip_phase = wpbe_pkg::PH_SECOND;
          end
          wpbe_pkg::PH_SECOND: begin
            if (!queue_byte(db)) ovf = 1'b1;
            if (!queue_byte(held)) ovf = 1'b1;
            trip_phase = wpbe_pkg::PH_THIRD;
          end
          default: begin
            if (!queue_byte(db)) ovf = 1'b1;
            trip_phase = wpbe_pkg::PH_FIRST;
          end
        endcase
      end
      wpbe_pkg::REQ_TICK: begin
        if (!tx_on && q_count > 0) begin
          shifter = byte_ram[q_head];
          q_head = (q_head + 1) % QUEUE_DEPTH;
          q_count--;
          bit_pos = 0;
          cell_cnt = 8'd0;
          tx_on = 1'b1;
        end
        if (!tx_on) begin
          line_q = 1'b0;
        end else begin
          hi = shifter[7 - bit_pos] ? one_hi : zero_hi;
          line_q = (cell_cnt < hi);
          if (int'(cell_cnt) + 1 >= int'(period)) begin
            cell_cnt = 8'd0;
            bit_pos++;
            if (bit_pos >= 8) begin
              bit_pos = 0;
              tx_on = 1'b0;
            end
          end else begin
            cell_cnt = cell_cnt + 8'd1;
          end
        end
      end
      wpbe_pkg::REQ_FLUSH: begin
        if (trip_phase == wpbe_pkg::PH_SECOND && !queue_byte(wpbe_pkg::FILL_BYTE))
          ovf = 1'b1;
        trip_phase = wpbe_pkg::PH_FIRST;
      end
      default: ;
    endcase
    r.line_level = line_q;
    r.busy_res   = tx_on || (q_count > 0);
    r.overflow   = ovf;
    if (ovf) dropped_items++;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] rt, input logic [7:0] db);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rt;
    req_ch.data_byte <= db;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    due_states.push_back(encode_item(rt, db));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(wpbe_pkg::REQ_TICK, 8'($urandom));
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(wpbe_pkg::REQ_DATA, r);
    send_item(wpbe_pkg::REQ_DATA, g);
    send_item(wpbe_pkg::REQ_DATA, b);
  endtask

  // stop offering and wait for every result to land
  task automatic wait_results();
    req_ch.valid <= 1'b0;
    while (due_states.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // tick until the line is idle, then wait for every result to land
  task automatic drain_line();
    while (tx_on || q_count > 0) send_item(wpbe_pkg::REQ_TICK, 8'($urandom));
    wait_results();
  endtask

  task automatic set_timing(input logic [7:0] zh, input logic [7:0] oh, input logic [7:0] bp);
    cfg_wr_en <= 1'b1;
    cfg_index <= wpbe_pkg::CFG_ZERO_HIGH;
    cfg_data  <= zh;
    @(negedge clk);
    cfg_index <= wpbe_pkg::CFG_ONE_HIGH;
    cfg_data  <= oh;
    @(negedge clk);
    cfg_index <= wpbe_pkg::CFG_BIT_PERIOD;
    cfg_data  <= bp;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    zero_hi = zh;
    one_hi  = oh;
    period  = bp;
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_ticks(2);
    send_item(REQ_UNKNOWN, 8'hFF);
    send_item(wpbe_pkg::REQ_FLUSH, 8'h00);
    send_item(wpbe_pkg::REQ_DATA, 8'hA5);
    send_item(wpbe_pkg::REQ_DATA, 8'h81);
    send_item(wpbe_pkg::REQ_FLUSH, 8'h5A);
    send_ticks(70);
    wait_results();
    set_timing(8'd1, 8'd2, 8'd2);
    drain_line();
  endtask

  task automatic test_triplet_order();
    set_timing(8'd1, 8'd2, 8'd2);
    send_pixel(8'h00, 8'hFF, 8'h80);
    send_ticks(20);
    send_item(REQ_UNKNOWN, 8'h00);
    send_item(wpbe_pkg::REQ_DATA, 8'hC3);
    send_item(wpbe_pkg::REQ_DATA, 8'h3C);
    send_item(wpbe_pkg::REQ_DATA, 8'h5A);
    send_item(wpbe_pkg::REQ_DATA, 8'h77);
    send_item(wpbe_pkg::REQ_FLUSH, 8'h00);
    drain_line();
  endtask

  task automatic test_extreme_timing();
    set_timing(8'd255, 8'd255, 8'd2);
    send_pixel(8'h00, 8'h55, 8'hAA);
    drain_line();
    set_timing(8'd1, 8'd255, 8'd4);
    send_item(wpbe_pkg::REQ_DATA, 8'h12);
    send_item(wpbe_pkg::REQ_DATA, 8'h80);
    send_item(wpbe_pkg::REQ_FLUSH, 8'h00);
    drain_line();
  endtask

  task automatic test_queue_overflow();
    set_timing(8'd1, 8'd1, 8'd2);
    repeat (6) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    send_item(wpbe_pkg::REQ_DATA, 8'hEE);
    send_item(wpbe_pkg::REQ_FLUSH, 8'h00);
    send_ticks(3);
    drain_line();
  endtask

  task automatic test_result_backpressure();
    hold_res = 1'b1;
    send_item(wpbe_pkg::REQ_DATA, 8'hFF);
    send_item(wpbe_pkg::REQ_FLUSH, 8'h00);
    send_ticks(30);
    drain_line();
  endtask

  task automatic random_phase(input int n);
    int done;
    int kind;
    int k;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        k = (kind < 5) ? $urandom_range(4, 7) : $urandom_range(1, 2);
        repeat (k) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        done += 3 * k;
      end else if (kind < 85) begin
        k = $urandom_range(1, 60);
        send_ticks(k);
        done += k;
      end else if (kind < 93) begin
        k = $urandom_range(0, 2);
        repeat (k) send_item(wpbe_pkg::REQ_DATA, 8'($urandom));
        send_item(wpbe_pkg::REQ_FLUSH, 8'($urandom));
        done += k + 1;
      end else if (kind < 98) begin
        send_item(2'($urandom_range(0, 2)), 8'($urandom));
        done++;
      end else begin
        send_item(REQ_UNKNOWN, 8'($urandom));
      end
    end
    drain_line();
  endtask

  task automatic test_random_traffic();
    set_timing(8'd1, 8'd2, 8'd2);
    random_phase(40);
    steady = 1'b1;
    set_timing(8'd2, 8'd1, 8'd3);
    random_phase(20);
    steady = 1'b0;
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin : res_ready_drive
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_res) begin
        hold_left = HOLD_CYCLES;
        hold_res  = 1'b0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        res_ch.ready <= 1'b0;
        gap_left--;
      end else begin
        res_ch.ready <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_res
    wpbe_pkg::res_t want;
    wpbe_pkg::res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.line_level = res_ch.line_level;
      got.busy_res   = res_ch.busy_res;
      got.overflow   = res_ch.overflow;
      if (due_states.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: result with nothing pending: line=%b busy=%b ovf=%b",
                   $realtime, got.line_level, got.busy_res, got.overflow);
      end else begin
        want = due_states.pop_front();
        checked_count++;
        if (got !== want) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: mismatch: expected line=%b busy=%b ovf=%b, got line=%b busy=%b ovf=%b",
                     $realtime, want.line_level, want.busy_res, want.overflow,
                     got.line_level, got.busy_res, got.overflow);
        end
      end
    end
  end

  initial begin
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = wpbe_pkg::REQ_DATA;
    req_ch.data_byte = 8'h00;
    cfg_wr_en        = 1'b0;
    cfg_index        = wpbe_pkg::CFG_ZERO_HIGH;
    cfg_data         = 8'h00;
    zero_hi    = wpbe_pkg::ZERO_HIGH_RST;
    one_hi     = wpbe_pkg::ONE_HIGH_RST;
    period     = wpbe_pkg::BIT_PERIOD_RST;
    q_head     = 0;
    q_tail     = 0;
    q_count    = 0;
    held       = 8'h00;
    trip_phase = wpbe_pkg::PH_FIRST;
    shifter    = 8'h00;
    bit_pos    = 0;
    cell_cnt   = 8'h00;
    tx_on      = 1'b0;
    line_q     = 1'b0;
    steady     = 1'b0;
    hold_res   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_triplet_order();
    test_extreme_timing();
    test_queue_overflow();
    test_result_backpressure();
    test_random_traffic();

    repeat (10) @(negedge clk);
    if (due_states.size() != 0) begin
      bad_count++;
      $display("%0d results never arrived", due_states.size());
    end
    $display("Sent %0d items under %0d timing settings, %0d items hit a full queue.",
             items_sent, settings_used, dropped_items);
    $display("Checked %0d results, %0d failures.", checked_count, bad_count);
    if (bad_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
